@@ src/tcalu_pkg.sv @@
package tcalu_pkg;

    localparam int DATA_W    = 64;
    localparam int HALF_W    = 32;
    localparam int DIV_STEPS = DATA_W;

    // operation codes
    localparam logic [4:0] OP_ADD    = 5'd0;
    localparam logic [4:0] OP_SUB    = 5'd1;
    localparam logic [4:0] OP_MUL    = 5'd2;
    localparam logic [4:0] OP_DIV    = 5'd3;
    localparam logic [4:0] OP_MOD    = 5'd4;
    localparam logic [4:0] OP_AND    = 5'd5;
    localparam logic [4:0] OP_OR     = 5'd6;
    localparam logic [4:0] OP_XOR    = 5'd7;
    localparam logic [4:0] OP_LSH    = 5'd8;
    localparam logic [4:0] OP_RSH    = 5'd9;
    localparam logic [4:0] OP_NEG    = 5'd10;
    localparam logic [4:0] OP_COMP   = 5'd11;
    localparam logic [4:0] OP_EQ     = 5'd12;
    localparam logic [4:0] OP_NEQ    = 5'd13;
    localparam logic [4:0] OP_GT     = 5'd14;
    localparam logic [4:0] OP_GEQ    = 5'd15;
    localparam logic [4:0] OP_LT     = 5'd16;
    localparam logic [4:0] OP_LEQ    = 5'd17;
    localparam logic [4:0] OP_ANDAND = 5'd18;
    localparam logic [4:0] OP_OROR   = 5'd19;
    localparam logic [4:0] OP_NOT    = 5'd20;

    // type kinds
    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_BIG  = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO    = 2'd1;
    localparam logic [1:0] ST_SHIFT_RANGE = 2'd2;
    localparam logic [1:0] ST_UNFOLDABLE  = 2'd3;

    typedef enum logic [1:0] {
        SEL_VAL,
        SEL_MUL,
        SEL_DIV,
        SEL_MOD
    } sel_t;

    // item context that travels down the pipeline
    typedef struct packed {
        sel_t              sel;
        logic [1:0]        kind;
        logic [DATA_W-1:0] val;
        logic              folded;
        logic [1:0]        status;
        logic              neg_q;
        logic              neg_r;
    } ctx_t;

endpackage

@@ src/typed_constant_integer_alu_top.sv @@
// channel  dir  tdata                                   tuser
// s_axis   in   [63:0] left_value, [127:64] right_value [4:0] op, [6:5] type_kind
// m_axis   out  [63:0] result                           [0] folded, [2:1] status
//
// one item enters per cycle while the output is not stalled
// the divider gives one quotient bit per stage over 64 stages
// rst_n clears all valid bits asynchronously; payload registers are not reset
// a stall at the output freezes the whole pipeline; s_axis_tready follows it
module typed_constant_integer_alu_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // left_value, right_value
    input  logic [6:0]   s_axis_tuser,  // op, type_kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // result
    output logic [2:0]   m_axis_tuser   // folded, status
);
    import tcalu_pkg::*;

    logic adv;

    // stage 1: input registers
    logic              in_valid_reg;
    logic [4:0]        in_op_reg;
    logic [1:0]        in_kind_reg;
    logic [DATA_W-1:0] in_a_reg;
    logic [DATA_W-1:0] in_b_reg;

    // stage 2: simple ops, partial products, magnitudes
    logic              ex_valid_reg;
    ctx_t              ex_ctx_reg;
    ctx_t              ex_ctx_next;
    logic [DATA_W-1:0] ex_pp_ll_reg;
    logic [DATA_W-1:0] ex_pp_lh_reg;
    logic [DATA_W-1:0] ex_pp_hl_reg;
    logic [DATA_W-1:0] ex_ma_reg;
    logic [DATA_W-1:0] ex_mb_reg;

    // divider stages
    logic              dv_valid_reg [0:DIV_STEPS];
    ctx_t              dv_ctx_reg   [0:DIV_STEPS];
    logic [DATA_W-1:0] dv_rem_reg   [0:DIV_STEPS];
    logic [DATA_W-1:0] dv_quo_reg   [0:DIV_STEPS];
    logic [DATA_W-1:0] dv_mb_reg    [0:DIV_STEPS];

    // output registers
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_result_reg;
    logic [DATA_W-1:0] out_result_next;
    logic              out_folded_reg;
    logic [1:0]        out_status_reg;

    // whole pipeline moves unless the output holds an item not yet taken
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_op_reg   <= s_axis_tuser[4:0];
            in_kind_reg <= s_axis_tuser[6:5];
            in_a_reg    <= s_axis_tdata[63:0];
            in_b_reg    <= s_axis_tdata[127:64];
        end
    end

    // decode and evaluate the operations that need neither multiplier nor divider
    logic [6:0]        width;
    logic [31:0]       cnt32;
    logic [5:0]        sh;
    logic              sh_bad;
    logic [DATA_W-1:0] shifted;

    always_comb
    begin
        unique case (in_kind_reg)
            KIND_INT:  width = 7'd32;
            KIND_BYTE: width = 7'd8;
            default:   width = 7'd64;
        endcase
        cnt32  = in_b_reg[31:0];
        sh_bad = cnt32[31] || (cnt32 >= {25'd0, width});
        sh     = sh_bad ? 6'd0 : cnt32[5:0];
        if (sh == 6'd0)
        begin
            shifted = in_a_reg;
        end
        else if (in_op_reg == OP_LSH)
        begin
            shifted = in_a_reg << sh;
        end
        else
        begin
            shifted = DATA_W'($signed(in_a_reg) >>> sh);
            if (in_kind_reg == KIND_INT && in_a_reg[31])
            begin
                shifted = shifted | ({DATA_W{1'b1}} << (6'd32 - sh));
            end
        end
    end

    always_comb
    begin
        ex_ctx_next        = '0;
        ex_ctx_next.sel    = SEL_VAL;
        ex_ctx_next.kind   = in_kind_reg;
        ex_ctx_next.folded = 1'b1;
        ex_ctx_next.status = ST_OK;
        ex_ctx_next.neg_q  = in_a_reg[DATA_W-1] ^ in_b_reg[DATA_W-1];
        ex_ctx_next.neg_r  = in_a_reg[DATA_W-1];
        if (in_kind_reg == KIND_BAD || in_op_reg > OP_NOT)
        begin
            ex_ctx_next.folded = 1'b0;
            ex_ctx_next.status = ST_UNFOLDABLE;
        end
        else
        begin
            unique case (in_op_reg)
                OP_ADD: ex_ctx_next.val = in_a_reg + in_b_reg;
                OP_SUB: ex_ctx_next.val = in_a_reg - in_b_reg;
                OP_MUL: ex_ctx_next.sel = SEL_MUL;
                OP_DIV, OP_MOD:
                begin
                    if (in_b_reg == '0)
                    begin
                        ex_ctx_next.folded = 1'b0;
                        ex_ctx_next.status = ST_DIV_ZERO;
                    end
                    else
                    begin
                        ex_ctx_next.sel = (in_op_reg == OP_DIV) ? SEL_DIV : SEL_MOD;
                    end
                end
                OP_AND: ex_ctx_next.val = in_a_reg & in_b_reg;
                OP_OR:  ex_ctx_next.val = in_a_reg | in_b_reg;
                OP_XOR: ex_ctx_next.val = in_a_reg ^ in_b_reg;
                OP_LSH, OP_RSH:
                begin
                    ex_ctx_next.val    = shifted;
                    ex_ctx_next.status = sh_bad ? ST_SHIFT_RANGE : ST_OK;
                end
                OP_NEG:  ex_ctx_next.val = '0 - in_a_reg;
                OP_COMP: ex_ctx_next.val = ~in_a_reg;
                OP_EQ:   ex_ctx_next.val = DATA_W'(in_a_reg == in_b_reg);
                OP_NEQ:  ex_ctx_next.val = DATA_W'(in_a_reg != in_b_reg);
                OP_GT:   ex_ctx_next.val = DATA_W'($signed(in_a_reg) > $signed(in_b_reg));
                OP_GEQ:  ex_ctx_next.val = DATA_W'($signed(in_a_reg) >= $signed(in_b_reg));
                OP_LT:   ex_ctx_next.val = DATA_W'($signed(in_a_reg) < $signed(in_b_reg));
                OP_LEQ:  ex_ctx_next.val = DATA_W'($signed(in_a_reg) <= $signed(in_b_reg));
                OP_ANDAND:
                    ex_ctx_next.val = DATA_W'(in_a_reg != '0 && in_b_reg != '0);
                OP_OROR:
                    ex_ctx_next.val = DATA_W'(in_a_reg != '0 || in_b_reg != '0);
                default: ex_ctx_next.val = DATA_W'(in_a_reg == '0);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ex_valid_reg <= in_valid_reg;
        end
    end

    // 32x32 partial products and operand magnitudes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_ctx_reg   <= ex_ctx_next;
            ex_pp_ll_reg <= in_a_reg[HALF_W-1:0] * in_b_reg[HALF_W-1:0];
            ex_pp_lh_reg <= in_a_reg[HALF_W-1:0] * in_b_reg[DATA_W-1:HALF_W];
            ex_pp_hl_reg <= in_a_reg[DATA_W-1:HALF_W] * in_b_reg[HALF_W-1:0];
            ex_ma_reg    <= in_a_reg[DATA_W-1] ? ('0 - in_a_reg) : in_a_reg;
            ex_mb_reg    <= in_b_reg[DATA_W-1] ? ('0 - in_b_reg) : in_b_reg;
        end
    end

    // product assembly and divider load
    ctx_t              ld_ctx;
    logic [HALF_W-1:0] cross_sum;

    always_comb
    begin
        ld_ctx    = ex_ctx_reg;
        cross_sum = ex_pp_lh_reg[HALF_W-1:0] + ex_pp_hl_reg[HALF_W-1:0];
        if (ex_ctx_reg.sel == SEL_MUL)
        begin
            ld_ctx.val = ex_pp_ll_reg + {cross_sum, {HALF_W{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg[0] <= ex_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_ctx_reg[0] <= ld_ctx;
            dv_rem_reg[0] <= '0;
            dv_quo_reg[0] <= ex_ma_reg;
            dv_mb_reg[0]  <= ex_mb_reg;
        end
    end

    // restoring divider, one quotient bit per stage
    genvar k;
    generate
        for (k = 1; k <= DIV_STEPS; k++)
        begin : g_div
            logic [DATA_W-1:0] trial;
            logic              ge;

            always_comb
            begin
                trial = {dv_rem_reg[k-1][DATA_W-2:0], dv_quo_reg[k-1][DATA_W-1]};
                ge    = trial >= dv_mb_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_valid_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    dv_valid_reg[k] <= dv_valid_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_ctx_reg[k] <= dv_ctx_reg[k-1];
                    dv_rem_reg[k] <= ge ? (trial - dv_mb_reg[k-1]) : trial;
                    dv_quo_reg[k] <= {dv_quo_reg[k-1][DATA_W-2:0], ge};
                    dv_mb_reg[k]  <= dv_mb_reg[k-1];
                end
            end
        end
    endgenerate

    // sign fix of quotient or remainder, then wrap to the type width; unfolded items give zero
    logic [DATA_W-1:0] pre;
    ctx_t              fin;

    always_comb
    begin
        fin = dv_ctx_reg[DIV_STEPS];
        unique case (fin.sel)
            SEL_DIV:
                pre = fin.neg_q ? ('0 - dv_quo_reg[DIV_STEPS]) : dv_quo_reg[DIV_STEPS];
            SEL_MOD:
                pre = fin.neg_r ? ('0 - dv_rem_reg[DIV_STEPS]) : dv_rem_reg[DIV_STEPS];
            default:
                pre = fin.val;
        endcase
        if (!fin.folded)
        begin
            out_result_next = '0;
        end
        else if (fin.kind == KIND_INT)
        begin
            out_result_next = {{HALF_W{pre[HALF_W-1]}}, pre[HALF_W-1:0]};
        end
        else if (fin.kind == KIND_BYTE)
        begin
            out_result_next = {{(DATA_W-8){1'b0}}, pre[7:0]};
        end
        else
        begin
            out_result_next = pre;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_result_reg <= out_result_next;
            out_folded_reg <= fin.folded;
            out_status_reg <= fin.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_result_reg;
    assign m_axis_tuser  = {out_status_reg, out_folded_reg};

endmodule

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcalu_pkg::*;

    localparam int LATENCY   = 68;
    localparam int STALL_CAP = 20000;

    typedef struct {
        logic [4:0]  op;
        logic [1:0]  kind;
        logic [63:0] lhs;
        logic [63:0] rhs;
    } alu_req_t;

    typedef struct {
        logic [63:0] value;
        logic        folded;
        logic [1:0]  status;
    } alu_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [6:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    alu_req_t pending_ops[$];
    alu_res_t expected_results[$];
    int       mismatch_count;
    int       quiet_cycles;
    bit       stimulus_done;
    bit       calm_phase;
    bit       in_taken;
    int       send_gap;
    int       recv_gap;

    typed_constant_integer_alu_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // wrap a 64-bit value to the width of its type
    function automatic logic [63:0] wrap_to_kind(logic [63:0] v, logic [1:0] kind);
        if (kind == KIND_INT)
            return {{32{v[31]}}, v[31:0]};
        if (kind == KIND_BYTE)
            return {56'd0, v[7:0]};
        return v;
    endfunction

    // fold one operation as the block should
    function automatic alu_res_t fold_constant(alu_req_t r);
        alu_res_t    res;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [63:0] v;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        logic [63:0] rem;
        logic [31:0] cnt;
        int          width;
        int          sh;
        a = r.lhs;
        b = r.rhs;
        v = '0;
        res.value  = '0;
        res.folded = 1'b0;
        res.status = ST_UNFOLDABLE;
        if (r.kind == KIND_BAD || r.op > OP_NOT)
            return res;
        res.status = ST_OK;
        width = (r.kind == KIND_INT) ? 32 : (r.kind == KIND_BYTE) ? 8 : 64;
        case (r.op)
            OP_ADD: v = a + b;
            OP_SUB: v = a - b;
            OP_MUL: v = a * b;
            OP_DIV, OP_MOD:
            begin
                if (b == 0)
                begin
                    res.status = ST_DIV_ZERO;
                    return res;
                end
                ma = a[63] ? -a : a;
                mb = b[63] ? -b : b;
                q = ma / mb;
                rem = ma % mb;
                if (a[63] ^ b[63])
                    q = -q;
                if (a[63])
                    rem = -rem;
                v = (r.op == OP_DIV) ? q : rem;
            end
            OP_AND: v = a & b;
            OP_OR:  v = a | b;
            OP_XOR: v = a ^ b;
            OP_LSH, OP_RSH:
            begin
                cnt = b[31:0];
                sh = 0;
                if (cnt[31] || cnt >= width)
                    res.status = ST_SHIFT_RANGE;
                else
                    sh = cnt;
                if (sh == 0)
                    v = a;
                else if (r.op == OP_LSH)
                    v = a << sh;
                else
                begin
                    v = a >>> sh;
                    if (r.kind == KIND_INT && a[31])
                        v = v | ({64{1'b1}} << (32 - sh));
                end
            end
            OP_NEG:    v = -a;
            OP_COMP:   v = ~a;
            OP_EQ:     v = (a == b);
            OP_NEQ:    v = (a != b);
            OP_GT:     v = (a > b);
            OP_GEQ:    v = (a >= b);
            OP_LT:     v = (a < b);
            OP_LEQ:    v = (a <= b);
            OP_ANDAND: v = (a != 0 && b != 0);
            OP_OROR:   v = (a != 0 || b != 0);
            default:   v = (a == 0);
        endcase
        res.value  = wrap_to_kind(v, r.kind);
        res.folded = 1'b1;
        return res;
    endfunction

    // operand with bias towards edge values
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return 64'(signed'($urandom_range(0, 8)) - 4);
            3: return {{32{1'b0}}, $urandom()};
            4: return {{56{1'b0}}, 8'($urandom())};
            5: return {{32{$urandom_range(0, 1) == 1}}, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [63:0] pick_count();
        case ($urandom_range(0, 5))
            0: return {$urandom(), $urandom()};
            1: return {$urandom(), 32'hffff_ffff - $urandom_range(0, 3)};
            default: return {$urandom(), 32'($urandom_range(0, 70))};
        endcase
    endfunction

    task automatic queue_op(logic [4:0] op, logic [1:0] kind, logic [63:0] lhs,
                            logic [63:0] rhs);
        alu_req_t r;
        r.op = op;
        r.kind = kind;
        r.lhs = lhs;
        r.rhs = rhs;
        pending_ops.push_back(r);
    endtask

    // stimulus
    initial
    begin
        logic [4:0]  op;
        logic [1:0]  kind;
        logic [63:0] lhs;
        // directed edge cases
        queue_op(OP_ADD, KIND_BIG, 64'h7fff_ffff_ffff_ffff, 64'd1);
        queue_op(OP_MUL, KIND_INT, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
        queue_op(OP_DIV, KIND_BIG, 64'd5, 64'd0);
        queue_op(OP_MOD, KIND_INT, 64'd5, 64'd0);
        queue_op(OP_DIV, KIND_BIG, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff);
        queue_op(OP_MOD, KIND_BIG, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff);
        queue_op(OP_DIV, KIND_INT, -64'sd7, 64'd2);
        queue_op(OP_MOD, KIND_INT, -64'sd7, 64'd2);
        queue_op(OP_MOD, KIND_BYTE, 64'd7, -64'sd2);
        queue_op(OP_LSH, KIND_INT, 64'd1, 64'd32);
        queue_op(OP_LSH, KIND_BYTE, 64'h81, -64'sd1);
        queue_op(OP_LSH, KIND_BIG, 64'd1, 64'd63);
        queue_op(OP_RSH, KIND_BYTE, 64'hff, 64'd4);
        queue_op(OP_RSH, KIND_INT, 64'hffff_ffff_8000_0000, 64'd31);
        queue_op(OP_RSH, KIND_INT, 64'h0000_0000_8000_0000, 64'd4);
        queue_op(OP_RSH, KIND_BIG, 64'h8000_0000_0000_0000, 64'd63);
        queue_op(OP_NEG, KIND_BYTE, 64'd1, 64'd0);
        queue_op(OP_COMP, KIND_INT, 64'd0, 64'd0);
        queue_op(OP_GT, KIND_BIG, 64'h8000_0000_0000_0000, 64'd1);
        queue_op(OP_LEQ, KIND_BIG, 64'd3, 64'd3);
        queue_op(OP_ANDAND, KIND_INT, 64'd1, 64'd0);
        queue_op(OP_OROR, KIND_INT, 64'd0, 64'd0);
        queue_op(OP_NOT, KIND_BYTE, 64'd0, 64'd9);
        queue_op(5'd21, KIND_INT, 64'd1, 64'd1);
        queue_op(OP_ADD, KIND_BAD, 64'd1, 64'd1);
        // random operations, every code and kind
        for (int i = 0; i < 1450; i++)
        begin
            op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(0, 20));
            kind = ($urandom_range(0, 29) == 0) ? KIND_BAD : 2'($urandom_range(0, 2));
            lhs = pick_operand();
            if ($urandom_range(0, 1) == 1)
                lhs = wrap_to_kind(lhs, kind);
            if (op == OP_LSH || op == OP_RSH)
                queue_op(op, kind, lhs, pick_count());
            else if ((op == OP_DIV || op == OP_MOD) && $urandom_range(0, 9) == 0)
                queue_op(op, kind, lhs, 64'd0);
            else
                queue_op(op, kind, lhs, pick_operand());
        end
        stimulus_done = 1'b1;
    end

    // reset
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // input handshake seen at the last rising edge
    always @(posedge clk)
    begin
        in_taken <= s_axis_tvalid && s_axis_tready;
    end

    // driver: presents items at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            calm_phase <= (pending_ops.size() < 200);
            if (!s_axis_tvalid || in_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    s_axis_tdata <= {pending_ops[0].rhs, pending_ops[0].lhs};
                    s_axis_tuser <= {pending_ops[0].kind, pending_ops[0].op};
                    s_axis_tvalid <= 1'b1;
                    expected_results.push_back(fold_constant(pending_ops[0]));
                    void'(pending_ops.pop_front());
                    if (!calm_phase && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 8);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            // receiver back-pressure
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm_phase && $urandom_range(0, 9) == 0)
                    recv_gap <= $urandom_range(1, 8);
            end
        end
    end

    // monitor: checks results at the rising edge
    always @(posedge clk)
    begin
        alu_res_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected item: result %h tuser %b", m_axis_tdata,
                             m_axis_tuser);
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (m_axis_tdata !== exp_res.value || m_axis_tuser[0] !== exp_res.folded
                    || m_axis_tuser[2:1] !== exp_res.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h/%b/%0d actual %h/%b/%0d",
                                 exp_res.value, exp_res.folded, exp_res.status,
                                 m_axis_tdata, m_axis_tuser[0], m_axis_tuser[2:1]);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // end of run
    initial
    begin
        send_gap = 0;
        recv_gap = 0;
        mismatch_count = 0;
        quiet_cycles = 0;
        calm_phase = 1'b0;
        wait (rst_n);
        while (!(stimulus_done && pending_ops.size() == 0 && !s_axis_tvalid
                 && expected_results.size() == 0) && quiet_cycles < STALL_CAP)
            @(posedge clk);
        if (quiet_cycles >= STALL_CAP)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            repeat (LATENCY + 10) @(posedge clk);
            if (mismatch_count == 0 && expected_results.size() == 0)
                $display("status: pass");
            else
                $display("status: fail");
            $finish;
        end
    end

endmodule
